[src/xsm_pkg.sv]
// ----------------------------------------------------------------------------
// xsm_pkg
// Shared types, constants and the microcode table of the X25519 engine.
// ----------------------------------------------------------------------------
`default_nettype none

package xsm_pkg;

  // field element and multiplier geometry
  localparam int FE_W    = 256;
  localparam int MUL_W   = 32;
  localparam int DIGITS  = FE_W / MUL_W;
  localparam int IDX_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int K_W     = $clog2(2 * DIGITS);
  localparam int CACC_W  = 2 * MUL_W + IDX_W + 1;
  localparam int PROD_W  = 2 * FE_W;
  localparam int T_W     = FE_W + 7;
  localparam int H38_W   = FE_W + 6;
  localparam int WORD_W  = 64;

  // input op codes
  localparam logic [1:0] OP_LOAD_SCALAR = 2'd0;
  localparam logic [1:0] OP_LOAD_POINT  = 2'd1;
  localparam logic [1:0] OP_START       = 2'd2;

  // 4p = 2^257 - 76, added before a subtraction so the result stays positive
  localparam logic [T_W-1:0] FOUR_P = (T_W'(1) << 257) - T_W'(76);

  // scalar clamping masks
  localparam logic [FE_W-1:0] CLAMP_CLR = (FE_W'(1) << 255) | FE_W'(7);
  localparam logic [FE_W-1:0] CLAMP_SET = FE_W'(1) << 254;

  localparam logic [16:0] A24_VALUE = 17'd121665;

  // working register addresses
  localparam logic [3:0] R_X1  = 4'd0;
  localparam logic [3:0] R_X2  = 4'd1;
  localparam logic [3:0] R_Z2  = 4'd2;
  localparam logic [3:0] R_X3  = 4'd3;
  localparam logic [3:0] R_Z3  = 4'd4;
  localparam logic [3:0] R_A   = 4'd5;
  localparam logic [3:0] R_AA  = 4'd6;
  localparam logic [3:0] R_B   = 4'd7;
  localparam logic [3:0] R_BB  = 4'd8;
  localparam logic [3:0] R_E   = 4'd9;
  localparam logic [3:0] R_C   = 4'd10;
  localparam logic [3:0] R_D   = 4'd11;
  localparam logic [3:0] R_DA  = 4'd12;
  localparam logic [3:0] R_CB  = 4'd13;
  localparam logic [3:0] R_A24 = 4'd14;
  localparam logic [3:0] R_RES = 4'd15;

  // constant selectors carried in the first source field
  localparam logic [3:0] CONST_ZERO = 4'd0;
  localparam logic [3:0] CONST_ONE  = 4'd1;
  localparam logic [3:0] CONST_A24  = 4'd2;

  // microcode segment bounds
  localparam logic [5:0] SETUP_FIRST = 6'd0;
  localparam logic [5:0] SETUP_LAST  = 6'd6;
  localparam logic [5:0] SWAP_FIRST  = 6'd7;
  localparam logic [5:0] SWAP_LAST   = 6'd12;
  localparam logic [5:0] STEP_FIRST  = 6'd13;
  localparam logic [5:0] STEP_LAST   = 6'd30;
  localparam logic [5:0] INVC_PC     = 6'd31;
  localparam logic [5:0] INVSQ_PC    = 6'd32;
  localparam logic [5:0] INVMUL_PC   = 6'd33;
  localparam logic [5:0] TAIL_FIRST  = 6'd34;
  localparam logic [5:0] TAIL_LAST   = 6'd35;

  typedef enum logic [2:0] {
    FOP_ADD,
    FOP_SUB,
    FOP_MUL,
    FOP_COPY,
    FOP_CONST,
    FOP_LOADU,
    FOP_CANON
  } fop_t;

  typedef struct packed {
    fop_t       op;
    logic [3:0] dst;
    logic [3:0] src_a;
    logic [3:0] src_b;
  } uinst_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [1:0]        word_index;
    logic [WORD_W-1:0] word_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        result_index;
    logic [WORD_W-1:0] result_word;
    logic              last_word;
  } out_item_t;

  typedef struct packed {
    logic       start;
    fop_t       op;
    logic [3:0] dst;
    logic [3:0] src_a;
    logic [3:0] src_b;
    logic [7:0] bit_index;
    logic       ld_scalar;
    logic       ld_point;
  } cmd_t;

  typedef struct packed {
    logic            done;
    logic            kbit;
    logic [FE_W-1:0] res_value;
  } status_t;

  function automatic uinst_t urom(input logic [5:0] pc);
    uinst_t u;
    u = '{op: FOP_COPY, dst: R_D, src_a: R_D, src_b: R_D};
    case (pc)
      6'd0:  u = '{op: FOP_LOADU, dst: R_X1,  src_a: R_X1,      src_b: R_X1};
      6'd1:  u = '{op: FOP_CANON, dst: R_X1,  src_a: R_X1,      src_b: R_X1};
      6'd2:  u = '{op: FOP_CONST, dst: R_X2,  src_a: CONST_ONE, src_b: R_X1};
      6'd3:  u = '{op: FOP_CONST, dst: R_Z2,  src_a: CONST_ZERO, src_b: R_X1};
      6'd4:  u = '{op: FOP_COPY,  dst: R_X3,  src_a: R_X1,      src_b: R_X1};
      6'd5:  u = '{op: FOP_CONST, dst: R_Z3,  src_a: CONST_ONE, src_b: R_X1};
      6'd6:  u = '{op: FOP_CONST, dst: R_A24, src_a: CONST_A24, src_b: R_X1};
      // conditional swap through a scratch register
      6'd7:  u = '{op: FOP_COPY,  dst: R_D,   src_a: R_X2, src_b: R_X2};
      6'd8:  u = '{op: FOP_COPY,  dst: R_X2,  src_a: R_X3, src_b: R_X3};
      6'd9:  u = '{op: FOP_COPY,  dst: R_X3,  src_a: R_D,  src_b: R_D};
      6'd10: u = '{op: FOP_COPY,  dst: R_D,   src_a: R_Z2, src_b: R_Z2};
      6'd11: u = '{op: FOP_COPY,  dst: R_Z2,  src_a: R_Z3, src_b: R_Z3};
      6'd12: u = '{op: FOP_COPY,  dst: R_Z3,  src_a: R_D,  src_b: R_D};
      // one ladder step
      6'd13: u = '{op: FOP_ADD,   dst: R_A,   src_a: R_X2,  src_b: R_Z2};
      6'd14: u = '{op: FOP_MUL,   dst: R_AA,  src_a: R_A,   src_b: R_A};
      6'd15: u = '{op: FOP_SUB,   dst: R_B,   src_a: R_X2,  src_b: R_Z2};
      6'd16: u = '{op: FOP_MUL,   dst: R_BB,  src_a: R_B,   src_b: R_B};
      6'd17: u = '{op: FOP_SUB,   dst: R_E,   src_a: R_AA,  src_b: R_BB};
      6'd18: u = '{op: FOP_ADD,   dst: R_C,   src_a: R_X3,  src_b: R_Z3};
      6'd19: u = '{op: FOP_SUB,   dst: R_D,   src_a: R_X3,  src_b: R_Z3};
      6'd20: u = '{op: FOP_MUL,   dst: R_DA,  src_a: R_D,   src_b: R_A};
      6'd21: u = '{op: FOP_MUL,   dst: R_CB,  src_a: R_C,   src_b: R_B};
      6'd22: u = '{op: FOP_ADD,   dst: R_X3,  src_a: R_DA,  src_b: R_CB};
      6'd23: u = '{op: FOP_MUL,   dst: R_X3,  src_a: R_X3,  src_b: R_X3};
      6'd24: u = '{op: FOP_SUB,   dst: R_Z3,  src_a: R_DA,  src_b: R_CB};
      6'd25: u = '{op: FOP_MUL,   dst: R_Z3,  src_a: R_Z3,  src_b: R_Z3};
      6'd26: u = '{op: FOP_MUL,   dst: R_Z3,  src_a: R_Z3,  src_b: R_X1};
      6'd27: u = '{op: FOP_MUL,   dst: R_X2,  src_a: R_AA,  src_b: R_BB};
      6'd28: u = '{op: FOP_MUL,   dst: R_Z2,  src_a: R_A24, src_b: R_E};
      6'd29: u = '{op: FOP_ADD,   dst: R_Z2,  src_a: R_Z2,  src_b: R_AA};
      6'd30: u = '{op: FOP_MUL,   dst: R_Z2,  src_a: R_Z2,  src_b: R_E};
      // inversion and final product
      6'd31: u = '{op: FOP_COPY,  dst: R_RES, src_a: R_Z2,  src_b: R_Z2};
      6'd32: u = '{op: FOP_MUL,   dst: R_RES, src_a: R_RES, src_b: R_RES};
      6'd33: u = '{op: FOP_MUL,   dst: R_RES, src_a: R_RES, src_b: R_Z2};
      6'd34: u = '{op: FOP_MUL,   dst: R_RES, src_a: R_RES, src_b: R_X2};
      6'd35: u = '{op: FOP_CANON, dst: R_RES, src_a: R_RES, src_b: R_RES};
      default: u = '{op: FOP_COPY, dst: R_D, src_a: R_D, src_b: R_D};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

[src/xsm_datapath.sv]
// ----------------------------------------------------------------------------
// xsm_datapath
// Operand stores, working register file and the mod 2^255-19 field unit.
// ----------------------------------------------------------------------------
`default_nettype none

module xsm_datapath (
  input  logic              clk,
  input  logic              rst,
  input  xsm_pkg::cmd_t     cmd,
  input  xsm_pkg::in_item_t in_data,
  output xsm_pkg::status_t  status
);

  localparam int FE_W   = xsm_pkg::FE_W;
  localparam int MUL_W  = xsm_pkg::MUL_W;
  localparam int IDX_W  = xsm_pkg::IDX_W;
  localparam int K_W    = xsm_pkg::K_W;
  localparam int CACC_W = xsm_pkg::CACC_W;
  localparam int PROD_W = xsm_pkg::PROD_W;
  localparam int T_W    = xsm_pkg::T_W;
  localparam int H38_W  = xsm_pkg::H38_W;
  localparam int WORD_W = xsm_pkg::WORD_W;
  localparam logic [K_W-1:0] KD1   = K_W'(xsm_pkg::DIGITS - 1);
  localparam logic [K_W-1:0] KLAST = K_W'(2 * xsm_pkg::DIGITS - 2);

  typedef enum logic [3:0] {
    D_IDLE,
    D_FETCH,
    D_MUL,
    D_RED1,
    D_RED2,
    D_FOLD,
    D_CSUB,
    D_WB
  } dstate_t;

  dstate_t              dstate;
  xsm_pkg::fop_t        op_r;
  logic [3:0]           dst_r;
  logic [3:0]           ca_r;
  logic [FE_W-1:0]      scalar;
  logic [FE_W-1:0]      point;
  logic [FE_W-1:0]      rf [16];
  logic [FE_W-1:0]      rd_a;
  logic [FE_W-1:0]      rd_b;
  logic [T_W-1:0]       t;
  logic [PROD_W-1:0]    prodreg;
  logic [H38_W-1:0]     h38;
  logic [CACC_W-1:0]    col;
  logic [CACC_W-1:0]    sum;
  logic [2*MUL_W-1:0]   prod;
  logic                 p_v;
  logic                 p_last;
  logic                 p_final;
  logic [IDX_W-1:0]     mi;
  logic [IDX_W-1:0]     mj;
  logic [K_W-1:0]       mk;
  logic [K_W-1:0]       kn;
  logic                 m_issue;
  logic                 col_last;
  logic [1:0]           fold_left;
  logic                 done;
  logic [FE_W-1:0]      res_value;
  logic [FE_W:0]        csum;
  logic [FE_W-1:0]      clamped;

  function automatic logic [IDX_W-1:0] imin(input logic [K_W-1:0] k);
    return (k > KD1) ? IDX_W'(k - KD1) : '0;
  endfunction

  function automatic logic [IDX_W-1:0] imax(input logic [K_W-1:0] k);
    return (k < KD1) ? IDX_W'(k) : IDX_W'(KD1);
  endfunction

  // bits 255 and up folded back in times 19
  function automatic logic [T_W-1:0] fold(input logic [T_W-1:0] v);
    logic [12:0] hi19;
    hi19 = {5'b0, v[T_W-1:255]} * 13'd19;
    return T_W'(v[254:0]) + T_W'(hi19);
  endfunction

  // operand stores
  always_ff @(posedge clk) begin
    if (cmd.ld_scalar) begin
      scalar[in_data.word_index*WORD_W +: WORD_W] <= in_data.word_value;
    end
    if (cmd.ld_point) begin
      point[in_data.word_index*WORD_W +: WORD_W] <= in_data.word_value;
    end
  end

  assign clamped = (scalar & ~xsm_pkg::CLAMP_CLR) | xsm_pkg::CLAMP_SET;

  // working registers: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (dstate == D_WB) begin
      rf[dst_r] <= t[FE_W-1:0];
    end
    if (cmd.start) begin
      rd_a <= rf[cmd.src_a];
      rd_b <= rf[cmd.src_b];
    end
  end

  assign sum      = col + CACC_W'(prod);
  assign col_last = (mi == imax(mk));
  assign kn       = mk + K_W'(1);
  assign csum     = {1'b0, t[FE_W-1:0]} + (FE_W+1)'(19);

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (dstate)
        D_IDLE: begin
          if (cmd.start) begin
            op_r   <= cmd.op;
            dst_r  <= cmd.dst;
            ca_r   <= cmd.src_a;
            dstate <= D_FETCH;
          end
        end
        D_FETCH: begin
          case (op_r)
            xsm_pkg::FOP_ADD: begin
              t         <= T_W'(rd_a) + T_W'(rd_b);
              fold_left <= 2'd1;
              dstate    <= D_FOLD;
            end
            xsm_pkg::FOP_SUB: begin
              t         <= T_W'(rd_a) + xsm_pkg::FOUR_P - T_W'(rd_b);
              fold_left <= 2'd1;
              dstate    <= D_FOLD;
            end
            xsm_pkg::FOP_MUL: begin
              col     <= '0;
              p_v     <= 1'b0;
              m_issue <= 1'b1;
              mi      <= '0;
              mj      <= '0;
              mk      <= '0;
              dstate  <= D_MUL;
            end
            xsm_pkg::FOP_CONST: begin
              case (ca_r)
                xsm_pkg::CONST_ONE: t <= T_W'(1);
                xsm_pkg::CONST_A24: t <= T_W'(xsm_pkg::A24_VALUE);
                default:            t <= '0;
              endcase
              dstate <= D_WB;
            end
            xsm_pkg::FOP_LOADU: begin
              t      <= T_W'(point[254:0]);
              dstate <= D_WB;
            end
            xsm_pkg::FOP_CANON: begin
              t         <= T_W'(rd_a);
              fold_left <= 2'd2;
              dstate    <= D_FOLD;
            end
            default: begin
              t      <= T_W'(rd_a);
              dstate <= D_WB;
            end
          endcase
        end
        D_MUL: begin
          // product scanning: one partial product issued per cycle
          if (m_issue) begin
            prod    <= rd_a[mi*MUL_W +: MUL_W] * rd_b[mj*MUL_W +: MUL_W];
            p_v     <= 1'b1;
            p_last  <= col_last;
            p_final <= col_last && (mk == KLAST);
            if (col_last) begin
              if (mk == KLAST) begin
                m_issue <= 1'b0;
              end else begin
                mk <= kn;
                mi <= imin(kn);
                mj <= IDX_W'(kn - {{(K_W-IDX_W){1'b0}}, imin(kn)});
              end
            end else begin
              mi <= mi + IDX_W'(1);
              mj <= mj - IDX_W'(1);
            end
          end else begin
            p_v <= 1'b0;
          end
          if (p_v) begin
            if (p_last) begin
              if (p_final) begin
                prodreg <= {sum[2*MUL_W-1:0], prodreg[PROD_W-1:2*MUL_W]};
                dstate  <= D_RED1;
              end else begin
                prodreg <= {sum[MUL_W-1:0], prodreg[PROD_W-1:MUL_W]};
                col     <= sum >> MUL_W;
              end
            end else begin
              col <= sum;
            end
          end
        end
        D_RED1: begin
          // 2^256 = 38 mod p
          h38 <= H38_W'({prodreg[PROD_W-1:FE_W], 5'b0})
               + H38_W'({prodreg[PROD_W-1:FE_W], 2'b0})
               + H38_W'({prodreg[PROD_W-1:FE_W], 1'b0});
          dstate <= D_RED2;
        end
        D_RED2: begin
          t         <= T_W'(prodreg[FE_W-1:0]) + T_W'(h38);
          fold_left <= 2'd1;
          dstate    <= D_FOLD;
        end
        D_FOLD: begin
          t         <= fold(t);
          fold_left <= fold_left - 2'd1;
          if (fold_left == 2'd1) begin
            dstate <= (op_r == xsm_pkg::FOP_CANON) ? D_CSUB : D_WB;
          end
        end
        D_CSUB: begin
          if (csum[255]) begin
            t <= T_W'(csum[254:0]);
          end
          dstate <= D_WB;
        end
        D_WB: begin
          done <= 1'b1;
          if (dst_r == xsm_pkg::R_RES) begin
            res_value <= t[FE_W-1:0];
          end
          dstate <= D_IDLE;
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end

  assign status.done      = done;
  assign status.kbit      = clamped[cmd.bit_index];
  assign status.res_value = res_value;

endmodule

`default_nettype wire

[src/xsm_ctrl.sv]
// ----------------------------------------------------------------------------
// xsm_ctrl
// Sequencer for ladder, inversion and result words; owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module xsm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  xsm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output xsm_pkg::out_item_t out_data,
  output xsm_pkg::cmd_t      cmd,
  input  xsm_pkg::status_t   status
);

  localparam int WORD_W = xsm_pkg::WORD_W;

  typedef enum logic [2:0] {
    C_IDLE,
    C_ISSUE,
    C_WAIT,
    C_HEAD,
    C_EMIT
  } cstate_t;

  typedef enum logic [2:0] {
    PH_SETUP,
    PH_SWAP,
    PH_STEP,
    PH_FSWAP,
    PH_INV
  } phase_t;

  cstate_t         state;
  phase_t          phase;
  logic [5:0]      pc;
  logic [7:0]      bitc;
  logic            swap_flag;
  logic            start_r;
  logic [1:0]      out_idx;
  logic [1:0]      idx_n;
  logic            in_accept;
  xsm_pkg::uinst_t ui;

  assign ui        = xsm_pkg::urom(pc);
  assign in_stall  = (state != C_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign idx_n     = out_idx + 2'd1;

  assign cmd.start     = start_r;
  assign cmd.op        = ui.op;
  assign cmd.dst       = ui.dst;
  assign cmd.src_a     = ui.src_a;
  assign cmd.src_b     = ui.src_b;
  assign cmd.bit_index = bitc;
  assign cmd.ld_scalar = in_accept && (in_data.op == xsm_pkg::OP_LOAD_SCALAR);
  assign cmd.ld_point  = in_accept && (in_data.op == xsm_pkg::OP_LOAD_POINT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_IDLE;
      phase     <= PH_SETUP;
      pc        <= xsm_pkg::SETUP_FIRST;
      bitc      <= '0;
      swap_flag <= 1'b0;
      start_r   <= 1'b0;
      out_valid <= 1'b0;
      out_idx   <= '0;
    end else begin
      start_r <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (in_accept && in_data.op == xsm_pkg::OP_START) begin
            phase     <= PH_SETUP;
            pc        <= xsm_pkg::SETUP_FIRST;
            swap_flag <= 1'b0;
            state     <= C_ISSUE;
          end
        end
        C_ISSUE: begin
          start_r <= 1'b1;
          state   <= C_WAIT;
        end
        C_HEAD: begin
          // swap only when the scalar bit differs from the last one
          if (swap_flag ^ status.kbit) begin
            phase <= PH_SWAP;
            pc    <= xsm_pkg::SWAP_FIRST;
          end else begin
            phase <= PH_STEP;
            pc    <= xsm_pkg::STEP_FIRST;
          end
          swap_flag <= status.kbit;
          state     <= C_ISSUE;
        end
        C_WAIT: begin
          if (status.done) begin
            state <= C_ISSUE;
            unique case (phase)
              PH_SETUP: begin
                if (pc == xsm_pkg::SETUP_LAST) begin
                  bitc  <= 8'd254;
                  state <= C_HEAD;
                end else begin
                  pc <= pc + 6'd1;
                end
              end
              PH_SWAP: begin
                if (pc == xsm_pkg::SWAP_LAST) begin
                  phase <= PH_STEP;
                  pc    <= xsm_pkg::STEP_FIRST;
                end else begin
                  pc <= pc + 6'd1;
                end
              end
              PH_STEP: begin
                if (pc != xsm_pkg::STEP_LAST) begin
                  pc <= pc + 6'd1;
                end else if (bitc != 8'd0) begin
                  bitc  <= bitc - 8'd1;
                  state <= C_HEAD;
                end else if (swap_flag) begin
                  phase <= PH_FSWAP;
                  pc    <= xsm_pkg::SWAP_FIRST;
                end else begin
                  phase <= PH_INV;
                  pc    <= xsm_pkg::INVC_PC;
                end
              end
              PH_FSWAP: begin
                if (pc == xsm_pkg::SWAP_LAST) begin
                  swap_flag <= 1'b0;
                  phase     <= PH_INV;
                  pc        <= xsm_pkg::INVC_PC;
                end else begin
                  pc <= pc + 6'd1;
                end
              end
              PH_INV: begin
                // exponent p-2: every bit set from 253 down except bits 4 and 2
                if (pc == xsm_pkg::INVC_PC) begin
                  bitc <= 8'd253;
                  pc   <= xsm_pkg::INVSQ_PC;
                end else if (pc == xsm_pkg::INVSQ_PC && bitc != 8'd2 && bitc != 8'd4) begin
                  pc <= xsm_pkg::INVMUL_PC;
                end else if (pc == xsm_pkg::INVSQ_PC || pc == xsm_pkg::INVMUL_PC) begin
                  if (bitc == 8'd0) begin
                    pc <= xsm_pkg::TAIL_FIRST;
                  end else begin
                    bitc <= bitc - 8'd1;
                    pc   <= xsm_pkg::INVSQ_PC;
                  end
                end else if (pc == xsm_pkg::TAIL_FIRST) begin
                  pc <= pc + 6'd1;
                end else begin
                  out_valid             <= 1'b1;
                  out_idx               <= 2'd0;
                  out_data.result_index <= 2'd0;
                  out_data.result_word  <= status.res_value[0 +: WORD_W];
                  out_data.last_word    <= 1'b0;
                  state                 <= C_EMIT;
                end
              end
              default: state <= C_IDLE;
            endcase
          end
        end
        C_EMIT: begin
          if (out_valid && !out_stall) begin
            if (out_idx == 2'd3) begin
              out_valid <= 1'b0;
              state     <= C_IDLE;
            end else begin
              out_idx               <= idx_n;
              out_data.result_index <= idx_n;
              out_data.result_word  <= status.res_value[idx_n*WORD_W +: WORD_W];
              out_data.last_word    <= (idx_n == 2'd3);
            end
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  // no new word taken while results are still going out
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while result words pending");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    status.done |-> (state == C_WAIT))
    else $error("field unit finished with no operation outstanding");

  a_no_instant_done: assert property (@(posedge clk) disable iff (rst)
    start_r |=> !status.done)
    else $error("field unit reported completion too early");

endmodule

`default_nettype wire

[src/x25519_scalar_multiply.sv]
// ----------------------------------------------------------------------------
// x25519_scalar_multiply
// X25519 scalar multiplication over 2^255-19 with a shared 32-bit multiplier.
// ----------------------------------------------------------------------------
// Input words carry an op: load a scalar word, load a u-coordinate word, or
// start. Loads are taken one per cycle while the block is idle and produce no
// output. A start clamps the scalar, reduces u, runs the 255-step Montgomery
// ladder, inverts Z and returns the canonical u-coordinate as four 64-bit
// words, least significant first, the fourth marked last_word.
// Each field multiply forms 64 partial products through the one 32x32
// multiplier, then reduces the result. The ladder runs ten multiplies per
// scalar bit and inversion runs 506 multiplies; every conditional swap adds
// six copies through a scratch register.
// in_stall stays high from start until the fourth word has been taken.
// The output word sits in a register; if out_stall is held, the block simply
// waits with the word unchanged. Reset clears the sequencer and field unit
// state only; loaded words are undefined until written and persist across
// starts.
// ----------------------------------------------------------------------------
`default_nettype none

module x25519_scalar_multiply (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  xsm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output xsm_pkg::out_item_t out_data
);

  xsm_pkg::cmd_t    cmd;
  xsm_pkg::status_t status;

  xsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

  xsm_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .in_data (in_data),
    .status  (status)
  );

endmodule

`default_nettype wire
